// File: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define WPID_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define WPID_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/wpid_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpid_pkg
// shared widths, defaults and register codes of the windowed pid controller
// ----------------------------------------------------------------------------
package wpid_pkg;

  // parameter defaults
  localparam int RING_DEPTH_DEF     = 256;
  localparam int SAMPLE_BITS_DEF    = 16;
  localparam int GAIN_FRAC_BITS_DEF = 8;

  // fixed register and field widths
  localparam int GAIN_W     = 16;
  localparam int WLEN_W     = 9;
  localparam int LIMIT_W    = 15;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // register reset values
  localparam logic [WLEN_W-1:0]  WLEN_RESET  = WLEN_W'(256);
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(32767);

  // configuration register codes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KP_GAIN    = 3'd0,
    REG_KI_GAIN    = 3'd1,
    REG_KD_GAIN    = 3'd2,
    REG_WINDOW_LEN = 3'd3,
    REG_OUT_LIMIT  = 3'd4
  } cfg_reg_t;

endpackage

// File: hdl/wpid_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpid_in_if
// sample channel: measured value and setpoint with valid/ready
// ----------------------------------------------------------------------------
interface wpid_in_if #(
  parameter int SAMPLE_BITS = wpid_pkg::SAMPLE_BITS_DEF
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] measured;
  logic signed [SAMPLE_BITS-1:0] target;

  modport source (output valid, output measured, output target, input ready);
  modport sink   (input valid, input measured, input target, output ready);
endinterface

// File: hdl/wpid_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpid_out_if
// result channel: clamped drive value with valid/ready
// ----------------------------------------------------------------------------
interface wpid_out_if ();
  logic                         valid;
  logic                         ready;
  logic [wpid_pkg::LIMIT_W-1:0] drive;

  modport source (output valid, output drive, input ready);
  modport sink   (input valid, input drive, output ready);
endinterface

// File: hdl/windowed_pid_controller_top.sv
// pipeline: four register stages, stage 1, stage 2, stage 3 and output, from input to result
// throughput: one sample per cycle when not stalled, set by the window-sum update and ring ram
// reset: synchronous, active high; clears pipeline, window sum and last error, resets registers
// after reset a clearing pass writes zero to all RING_DEPTH ring entries, one per cycle;
// samples.ready stays low during the pass, configuration writes are taken as ever
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// windowed_pid_controller_top
// pid controller whose integral term is a sum over a sliding window of errors
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module windowed_pid_controller_top #(
  parameter int RING_DEPTH     = wpid_pkg::RING_DEPTH_DEF,
  parameter int GAIN_FRAC_BITS = wpid_pkg::GAIN_FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [wpid_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [wpid_pkg::CFG_DATA_W-1:0]     cfg_data,
  wpid_in_if.sink                             samples,
  wpid_out_if.source                          results
);

  // sample width is fixed to the package default
  localparam int SAMPLE_BITS = wpid_pkg::SAMPLE_BITS_DEF;

  // derived widths
  localparam int IDX_W   = $clog2(RING_DEPTH);
  localparam int E_W     = SAMPLE_BITS + 1;            // error
  localparam int D_W     = E_W + 1;                    // error difference
  localparam int SUM_W   = E_W + IDX_W;                // window sum
  localparam int GAIN_W  = wpid_pkg::GAIN_W;
  localparam int LIMIT_W = wpid_pkg::LIMIT_W;
  localparam int WLEN_W  = wpid_pkg::WLEN_W;
  localparam int ACC_W   = GAIN_W + SUM_W + 2;         // sum of three products
  localparam int RES_W   = ACC_W - GAIN_FRAC_BITS;
  localparam int CMP_W   = (IDX_W + 1 > WLEN_W) ? IDX_W + 1 : WLEN_W;

  // configuration registers
  logic signed [GAIN_W-1:0] kp_gain;
  logic signed [GAIN_W-1:0] ki_gain;
  logic signed [GAIN_W-1:0] kd_gain;
  logic [WLEN_W-1:0]        window_len;
  logic [LIMIT_W-1:0]       out_limit;

  // controller state
  logic [IDX_W-1:0]         ring_index;
  logic [IDX_W-1:0]         ring_index_next;
  logic signed [SUM_W-1:0]  window_sum;
  logic signed [E_W-1:0]    last_error;

  // ring clearing pass
  logic                     clr_active;
  logic [IDX_W-1:0]         clr_addr;

  // stage valids and flow control
  logic s1_valid, s2_valid, s3_valid, out_valid;
  logic s1_free, s2_free, s3_free, out_free;
  logic accept, s1_move;

  // stage 1: captured sample, ring slot and forwarding info
  logic signed [SAMPLE_BITS-1:0] s1_measured;
  logic signed [SAMPLE_BITS-1:0] s1_target;
  logic [IDX_W-1:0]              s1_idx;
  logic                          s1_fwd;
  logic signed [E_W-1:0]         s1_fwd_data;

  // stage 1 combinational terms
  logic signed [E_W-1:0]   e;
  logic signed [E_W-1:0]   old_e;
  logic signed [SUM_W-1:0] sum_next;
  logic signed [D_W-1:0]   d;

  // stage 2: multiplier operands
  logic signed [E_W-1:0]   s2_e;
  logic signed [SUM_W-1:0] s2_sum;
  logic signed [D_W-1:0]   s2_d;

  // stage 3: products
  logic signed [GAIN_W+E_W-1:0]   s3_kp;
  logic signed [GAIN_W+SUM_W-1:0] s3_ki;
  logic signed [GAIN_W+D_W-1:0]   s3_kd;

  // output stage
  logic signed [ACC_W-1:0] acc;
  logic [RES_W-1:0]        res;
  logic [LIMIT_W-1:0]      drive_next;
  logic [LIMIT_W-1:0]      drive;

  // ring ram ports
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [E_W-1:0]   ram_wdata;
  logic [E_W-1:0]   ram_rdata;

  // ---------------------------------------------------------------------------
  // flow control: each stage loads when empty or when it empties itself
  // ---------------------------------------------------------------------------
  assign out_free = !out_valid || results.ready;
  assign s3_free  = !s3_valid || out_free;
  assign s2_free  = !s2_valid || s3_free;
  assign s1_free  = !s1_valid || s2_free;

  // no sample transfer while the ring is being cleared
  assign samples.ready = s1_free && !clr_active;
  assign accept        = samples.valid && samples.ready;
  assign s1_move       = s1_valid && s2_free;

  assign results.valid = out_valid;
  assign results.drive = drive;

  // ---------------------------------------------------------------------------
  // ring index: advance, wrap at the effective window length
  // a zero window length always wraps (acts as one), a length above the
  // ring depth wraps at the depth
  // ---------------------------------------------------------------------------
  always_comb begin
    logic [IDX_W:0] inc;
    inc = {1'b0, ring_index} + (IDX_W + 1)'(1);
    if ((CMP_W'(inc) >= CMP_W'(RING_DEPTH)) || (CMP_W'(inc) >= CMP_W'(window_len))) begin
      ring_index_next = '0;
    end else begin
      ring_index_next = inc[IDX_W-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // error ring memory
  // read is issued at the input transfer, data is ready in stage 1;
  // the write of the item leaving stage 1 happens at the same edge, so a
  // read of that slot gets the new error through the forwarding register
  // ---------------------------------------------------------------------------
  assign ram_we    = clr_active || s1_move;
  assign ram_waddr = clr_active ? clr_addr : s1_idx;
  assign ram_wdata = clr_active ? '0 : e;

  wpid_ram #(
    .WIDTH (E_W),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (ring_index),
    .rdata (ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // stage 1 datapath: error, window sum update, difference
  // ---------------------------------------------------------------------------
  assign e        = E_W'(s1_target) - E_W'(s1_measured);
  assign old_e    = s1_fwd ? s1_fwd_data : ram_rdata;
  assign sum_next = window_sum - SUM_W'(old_e) + SUM_W'(e);
  assign d        = D_W'(e) - D_W'(last_error);

  // ---------------------------------------------------------------------------
  // output stage: sum of products, floor shift, clamp to [0, out_limit]
  // ---------------------------------------------------------------------------
  assign acc = ACC_W'(s3_kp) + ACC_W'(s3_ki) + ACC_W'(s3_kd);
  assign res = acc[ACC_W-1:GAIN_FRAC_BITS];

  always_comb begin
    if (acc[ACC_W-1]) begin
      drive_next = '0;
    end else if (res > RES_W'(out_limit)) begin
      drive_next = out_limit;
    end else begin
      drive_next = res[LIMIT_W-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // control state
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      kp_gain    <= '0;
      ki_gain    <= '0;
      kd_gain    <= '0;
      window_len <= wpid_pkg::WLEN_RESET;
      out_limit  <= wpid_pkg::LIMIT_RESET;
      ring_index <= '0;
      window_sum <= '0;
      last_error <= '0;
      clr_active <= 1'b1;
      clr_addr   <= '0;
      s1_valid   <= 1'b0;
      s2_valid   <= 1'b0;
      s3_valid   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      // register writes; unknown indexes are dropped
      if (cfg_we) begin
        unique case (cfg_index)
          wpid_pkg::REG_KP_GAIN:    kp_gain    <= cfg_data[GAIN_W-1:0];
          wpid_pkg::REG_KI_GAIN:    ki_gain    <= cfg_data[GAIN_W-1:0];
          wpid_pkg::REG_KD_GAIN:    kd_gain    <= cfg_data[GAIN_W-1:0];
          wpid_pkg::REG_WINDOW_LEN: window_len <= cfg_data[WLEN_W-1:0];
          wpid_pkg::REG_OUT_LIMIT:  out_limit  <= cfg_data[LIMIT_W-1:0];
          default: ;
        endcase
      end

      // clearing sweep over the ring after reset
      if (clr_active) begin
        clr_addr <= clr_addr + IDX_W'(1);
        if (clr_addr == IDX_W'(RING_DEPTH - 1)) begin
          clr_active <= 1'b0;
        end
      end

      if (accept) begin
        ring_index <= ring_index_next;
      end

      // state recurrence closes in stage 1: window sum and last error update as the item leaves stage 1
      if (s1_move) begin
        window_sum <= sum_next;
        last_error <= e;
      end

      if (s1_free) begin
        s1_valid <= accept;
      end
      if (s2_free) begin
        s2_valid <= s1_valid;
      end
      if (s3_free) begin
        s3_valid <= s2_valid;
      end
      if (out_free) begin
        out_valid <= s3_valid;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // payload registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_measured <= samples.measured;
      s1_target   <= samples.target;
      s1_idx      <= ring_index;
      // forward when the slot being read is the one written by the item leaving stage 1
      s1_fwd      <= s1_move && (s1_idx == ring_index);
      s1_fwd_data <= e;
    end
    if (s1_move) begin
      s2_e   <= e;
      s2_sum <= sum_next;
      s2_d   <= d;
    end
    if (s2_valid && s3_free) begin
      s3_kp <= kp_gain * s2_e;
      s3_ki <= ki_gain * s2_sum;
      s3_kd <= kd_gain * s2_d;
    end
    if (s3_valid && out_free) begin
      drive <= drive_next;
    end
  end

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  `WPID_ASSERT_NOW(a_drive_in_limit, results.valid, results.drive <= out_limit, "drive above out_limit")
  `WPID_ASSERT_NEXT(a_index_step, accept, (ring_index == $past(ring_index) + IDX_W'(1)) || (ring_index == '0), "ring index skipped")
  `WPID_ASSERT_NOW(a_clear_len, $fell(clr_active), $past(clr_addr) == IDX_W'(RING_DEPTH - 1), "clearing pass ended early")
  `WPID_ASSERT_NEXT(a_s1_handoff, s1_move, s2_valid, "stage 1 item lost")

endmodule

// File: hdl/wpid_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpid_ram
// generic simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module wpid_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
